/* rtl/bvf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvf_pkg
// Shared constants, register codes and types of the battery voltage filter.
// ----------------------------------------------------------------------------
package bvf_pkg;

    localparam int ADC_BITS     = 12;
    localparam int SAMPLE_W     = 12;
    localparam int FILTER_SHIFT = 13;
    localparam int MV_W         = 15;
    localparam int ACC_W        = MV_W + FILTER_SHIFT;
    localparam int CNT_W        = 8;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam int SCALE_MUL    = 271;
    localparam int SCALE_SHIFT  = 6;
    localparam int MV_MAX       = (1 << MV_W) - 1;

    localparam logic [MV_W-1:0]  LOW_THRESHOLD_RESET  = MV_W'(10500);
    localparam logic [MV_W-1:0]  HIGH_THRESHOLD_RESET = MV_W'(11000);
    localparam logic [CNT_W-1:0] SETTLE_COUNT_RESET   = CNT_W'(100);

    typedef enum logic [1:0] {
        REG_LOW_THRESHOLD  = 2'd0,
        REG_HIGH_THRESHOLD = 2'd1,
        REG_SETTLE_COUNT   = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [MV_W-1:0]  low_threshold;
        logic [MV_W-1:0]  high_threshold;
        logic [CNT_W-1:0] settle_count;
    } cfg_t;

    typedef struct packed {
        logic [MV_W-1:0] filtered_mv;
        logic            low_battery;
        logic            settled;
    } result_t;

endpackage

/* rtl/bvf_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvf_scale
// Converts a raw converter sample to millivolts as floor(sample*271/64),
// saturated to the range of the filtered value.
// ----------------------------------------------------------------------------
module bvf_scale (
    input  logic [bvf_pkg::SAMPLE_W-1:0] adc_sample,
    output logic [bvf_pkg::MV_W-1:0]     mv
);

    localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << bvf_pkg::ADC_BITS) - 64'd1);

    logic [31:0] sample;
    logic [31:0] product;
    logic [31:0] scaled;

    always_comb
    begin
        sample  = 32'(adc_sample) & SAMPLE_MASK;
        product = sample * 32'(bvf_pkg::SCALE_MUL);
        scaled  = product >> bvf_pkg::SCALE_SHIFT;
        if (scaled > 32'(bvf_pkg::MV_MAX))
        begin
            mv = bvf_pkg::MV_W'(bvf_pkg::MV_MAX);
        end
        else
        begin
            mv = scaled[bvf_pkg::MV_W-1:0];
        end
    end

endmodule

/* rtl/bvf_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvf_filter
// Holds the filter state and computes the result of one item: direct load
// during settling, first-order low-pass afterwards, and the hysteresis flag.
// ----------------------------------------------------------------------------
module bvf_filter (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     update,
    input  logic [bvf_pkg::MV_W-1:0] mv,
    input  bvf_pkg::cfg_t            cfg,
    output bvf_pkg::result_t         result
);

    localparam int FS = bvf_pkg::FILTER_SHIFT;

    logic [bvf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [bvf_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [bvf_pkg::MV_W-1:0]  fv_reg, fv_next;
    logic                      flag_reg, flag_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        fv_next   = fv_reg;
        flag_next = flag_reg;
        if (update)
        begin
            if (cnt_reg < cfg.settle_count)
            begin
                fv_next  = mv;
                acc_next = {mv, {FS{1'b0}}};
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                acc_next = acc_reg + bvf_pkg::ACC_W'(mv) - bvf_pkg::ACC_W'(fv_reg);
                fv_next  = acc_next[bvf_pkg::ACC_W-1:FS];
            end
            if (fv_next < cfg.low_threshold)
            begin
                flag_next = 1'b1;
            end
            if (fv_next > cfg.high_threshold)
            begin
                flag_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.filtered_mv = fv_next;
        result.low_battery = flag_next;
        result.settled     = (cnt_next >= cfg.settle_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            acc_reg  <= '0;
            fv_reg   <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            fv_reg   <= fv_next;
            flag_reg <= flag_next;
        end
    end

`ifndef SYNTHESIS
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> $stable(cnt_reg) && $stable(acc_reg) && $stable(flag_reg))
        else $error("filter state changed without an item");

    a_acc_matches_value: assert property (@(posedge clk) disable iff (!rst_n)
        fv_reg == acc_reg[bvf_pkg::ACC_W-1:FS])
        else $error("filtered value out of step with accumulator");

    a_counter_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == {bvf_pkg::CNT_W{1'b1}} |=> cnt_reg == {bvf_pkg::CNT_W{1'b1}})
        else $error("startup counter wrapped");
`endif

endmodule

/* rtl/battery_voltage_filter_lowbat_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_filter_lowbat_core
// Battery voltage filter with low-battery hysteresis and register port.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   adc_sample
// output    out        out_valid / out_stall filtered_mv, low_battery, settled
// config    in         APB write/read        low/high threshold, settle count
//
// One item per cycle is sustained while out_stall is low; an accepted item
// passes the scaled input register, then is valid in the result register.
// The filter state updates in the same cycle that a result register loads.
// Reset clears the filter state and restores the register defaults.
// A stalled output holds its result; the input register still accepts one
// more item, after which in_stall rises.
// ----------------------------------------------------------------------------
module battery_voltage_filter_lowbat_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bvf_pkg::SAMPLE_W-1:0] adc_sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bvf_pkg::MV_W-1:0]     filtered_mv,
    output logic                         low_battery,
    output logic                         settled,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bvf_pkg::ADDR_W-1:0]   paddr,
    input  logic [bvf_pkg::DATA_W-1:0]   pwdata,
    output logic [bvf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    bvf_pkg::cfg_t      cfg_reg, cfg_next;
    bvf_pkg::reg_index_t reg_sel;
    logic               wr_en;

    logic                     in_vld_reg, in_vld_next;
    logic [bvf_pkg::MV_W-1:0] mv_reg, mv_next;
    logic [bvf_pkg::MV_W-1:0] mv_scaled;
    logic                     out_vld_reg, out_vld_next;
    bvf_pkg::result_t         res_reg, res_next;
    bvf_pkg::result_t         filt_result;
    logic                     advance;
    logic                     in_take;

    assign pready  = 1'b1;
    assign reg_sel = bvf_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                bvf_pkg::REG_LOW_THRESHOLD:  cfg_next.low_threshold  = pwdata[bvf_pkg::MV_W-1:0];
                bvf_pkg::REG_HIGH_THRESHOLD: cfg_next.high_threshold = pwdata[bvf_pkg::MV_W-1:0];
                bvf_pkg::REG_SETTLE_COUNT:   cfg_next.settle_count   = pwdata[bvf_pkg::CNT_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            bvf_pkg::REG_LOW_THRESHOLD:  prdata = bvf_pkg::DATA_W'(cfg_reg.low_threshold);
            bvf_pkg::REG_HIGH_THRESHOLD: prdata = bvf_pkg::DATA_W'(cfg_reg.high_threshold);
            bvf_pkg::REG_SETTLE_COUNT:   prdata = bvf_pkg::DATA_W'(cfg_reg.settle_count);
            default:                     prdata = '0;
        endcase
    end

    bvf_scale u_scale (
        .adc_sample (adc_sample),
        .mv         (mv_scaled)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    bvf_filter u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .mv     (mv_reg),
        .cfg    (cfg_reg),
        .result (filt_result)
    );

    always_comb
    begin
        in_vld_next  = in_take || (in_vld_reg && !advance);
        mv_next      = in_take ? mv_scaled : mv_reg;
        out_vld_next = advance || (out_vld_reg && out_stall);
        res_next     = advance ? filt_result : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold  <= bvf_pkg::LOW_THRESHOLD_RESET;
            cfg_reg.high_threshold <= bvf_pkg::HIGH_THRESHOLD_RESET;
            cfg_reg.settle_count   <= bvf_pkg::SETTLE_COUNT_RESET;
            in_vld_reg             <= 1'b0;
            out_vld_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg  <= mv_next;
        res_reg <= res_next;
    end

    assign out_valid   = out_vld_reg;
    assign filtered_mv = res_reg.filtered_mv;
    assign low_battery = res_reg.low_battery;
    assign settled     = res_reg.settled;

`ifndef SYNTHESIS
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_vld_reg && out_stall) |-> in_stall)
        else $error("input taken while both stages are blocked");
`endif

endmodule
